>>> rtl/core/iq_correlation_demodulator_assert.svh
// Assertion macros for the I/Q correlation demodulator.
// Clocked on clk and disabled during rst; included by the top level only.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef IQ_CORRELATION_DEMODULATOR_ASSERT_SVH
`define IQ_CORRELATION_DEMODULATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IQCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define IQCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IQCD_ASSERT_NOW(label, ante, cons, msg)
`define IQCD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/core/iqcd_pkg.sv
// Shared types, constants and the quarter-wave cosine generator.
// No dependencies; used by every module of the I/Q correlation demodulator.
`timescale 1ns / 1ps
`default_nettype none

package iqcd_pkg;

  localparam int SAMPLE_W      = 12;
  localparam int PHASE_W       = 32;
  localparam int MAX_ADDR_BITS = 14;
  localparam int ROM_W         = 15;
  localparam int TRIG_W        = 16;
  localparam int PROD_W        = 28;
  localparam int SUM_W         = 40;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam int          TAYLOR_TERMS = 14;

  typedef enum logic [1:0] {
    QUAD_FIRST,
    QUAD_SECOND,
    QUAD_THIRD,
    QUAD_FOURTH
  } quadrant_t;

  // One accepted sample on its way to the multiply-accumulate side.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] centered;
    logic [MAX_ADDR_BITS-1:0]   phase_top;
    logic                       last;
  } item_t;

  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

  function automatic logic [63:0] mul_high(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] w;
    w = 128'(a) * 128'(b);
    return w[127:64];
  endfunction

  // Divide by (2n-1)*2n for one Taylor term.
  function automatic logic [63:0] taylor_div(input logic [63:0] v, input int n);
    case (n)
      1:       return v / 64'd2;
      2:       return v / 64'd12;
      3:       return v / 64'd30;
      4:       return v / 64'd56;
      5:       return v / 64'd90;
      6:       return v / 64'd132;
      7:       return v / 64'd182;
      8:       return v / 64'd240;
      9:       return v / 64'd306;
      10:      return v / 64'd380;
      11:      return v / 64'd462;
      12:      return v / 64'd552;
      13:      return v / 64'd650;
      14:      return v / 64'd756;
      default: return v;
    endcase
  endfunction

  // round(32767 * cos(k * pi / 2^(qbits+1))) in Q62 fixed point; elaboration only.
  function automatic logic [TRIG_W-1:0] quarter_cos(input int qbits, input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] r;
    x  = mul_high(HALF_PI_Q62, 64'(k) << (64 - qbits));
    x2 = mul_high(x, x) << 2;
    t  = ONE_Q62;
    for (int n = TAYLOR_TERMS; n >= 1; n--) begin
      p = taylor_div(mul_high(x2, t) << 2, n);
      t = ONE_Q62 - p;
    end
    r = mul_high(t << 1, 64'd32767 << 32);
    return TRIG_W'((r + (64'd1 << 30)) >> 31);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/iqcd_front.sv
// Front side: step register, phase accumulator, sample centering.
// Pushes one item into the queue per accepted sample; uses iqcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iqcd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [31:0]                     cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [11:0]                     sample,
  input  logic                            last_sample,
  input  iqcd_pkg::queue_status_t         q_status,
  output logic                            push,
  output iqcd_pkg::item_t                 push_item
);
  import iqcd_pkg::*;

  logic [PHASE_W-1:0] phase_step;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  // Flip the top bit: offset binary to two's complement, i.e. subtract mid-scale.
  assign push_item.centered  = {~sample[SAMPLE_W-1], sample[SAMPLE_W-2:0]};
  assign push_item.phase_top = phase[PHASE_W-1 -: MAX_ADDR_BITS];
  assign push_item.last      = last_sample;

  // Restart the phase at zero after the frame's last sample.
  assign phase_next = last_sample ? '0 : phase + phase_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      phase      <= '0;
    end else begin
      if (cfg_wr_en) begin
        phase_step <= cfg_wr_data;
      end
      if (push) begin
        phase <= phase_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/iqcd_queue.sv
// Short first-in first-out queue between the front and back sides.
// Holds iqcd_pkg::item_t entries; uses iqcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iqcd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  iqcd_pkg::item_t         push_item,
  input  logic                    pop,
  output iqcd_pkg::item_t         pop_item,
  output iqcd_pkg::queue_status_t status
);
  import iqcd_pkg::*;

  item_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign pop_item      = entries[rd_ptr];
  assign status.count  = count;
  assign status.full   = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status.empty  = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/iqcd_back.sv
// Back side: cosine/sine lookup, two multiplies, saturating 40-bit sums, result register.
// Quarter-wave table is built at elaboration from iqcd_pkg::quarter_cos.
`timescale 1ns / 1ps
`default_nettype none

module iqcd_back #(
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  iqcd_pkg::queue_status_t q_status,
  output logic                    pop,
  input  iqcd_pkg::item_t         pop_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [39:0]      in_phase_sum,
  output logic signed [39:0]      quadrature_sum,
  output logic                    saturated
);
  import iqcd_pkg::*;

  localparam int QB   = TABLE_ADDR_BITS - 2;
  localparam int QLEN = 1 << QB;

  logic [ROM_W-1:0] quarter_rom [QLEN];

  for (genvar k = 0; k < QLEN; k++) begin : g_rom
    assign quarter_rom[k] = ROM_W'(quarter_cos(QB, k));
  end

  logic                        adv;
  logic [TABLE_ADDR_BITS-1:0]  idx;
  quadrant_t                   quad;
  logic [QB-1:0]               j;
  logic [QB-1:0]               j_mir;
  logic signed [TRIG_W-1:0]    tab_a;
  logic signed [TRIG_W-1:0]    tab_b;
  logic signed [TRIG_W-1:0]    cos_val;
  logic signed [TRIG_W-1:0]    sin_val;

  logic                        s1_valid;
  logic                        s1_last;
  logic signed [SAMPLE_W-1:0]  s1_centered;
  logic signed [TRIG_W-1:0]    s1_cos;
  logic signed [TRIG_W-1:0]    s1_sin;

  logic                        s2_valid;
  logic                        s2_last;
  logic signed [PROD_W-1:0]    s2_prod_i;
  logic signed [PROD_W-1:0]    s2_prod_q;

  logic signed [SUM_W-1:0]     acc_i;
  logic signed [SUM_W-1:0]     acc_q;
  logic                        sat_flag;
  logic signed [SUM_W:0]       sum_i;
  logic signed [SUM_W:0]       sum_q;
  logic                        ovf_i;
  logic                        ovf_q;
  logic signed [SUM_W-1:0]     clip_i;
  logic signed [SUM_W-1:0]     clip_q;

  // Whole side advances unless a finished result is still waiting.
  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_status.empty;

  assign idx   = pop_item.phase_top[MAX_ADDR_BITS-1 -: TABLE_ADDR_BITS];
  assign quad  = quadrant_t'(idx[TABLE_ADDR_BITS-1 -: 2]);
  assign j     = idx[QB-1:0];
  assign j_mir = ~j + {{(QB-1){1'b0}}, 1'b1};
  assign tab_a = TRIG_W'(quarter_rom[j]);
  assign tab_b = (j == '0) ? '0 : TRIG_W'(quarter_rom[j_mir]);

  always_comb begin
    case (quad)
      QUAD_FIRST: begin
        cos_val = tab_a;
        sin_val = tab_b;
      end
      QUAD_SECOND: begin
        cos_val = -tab_b;
        sin_val = tab_a;
      end
      QUAD_THIRD: begin
        cos_val = -tab_a;
        sin_val = -tab_b;
      end
      QUAD_FOURTH: begin
        cos_val = tab_b;
        sin_val = -tab_a;
      end
      default: begin
        cos_val = tab_a;
        sin_val = tab_b;
      end
    endcase
  end

  assign sum_i  = (SUM_W+1)'(acc_i) + (SUM_W+1)'(s2_prod_i);
  assign sum_q  = (SUM_W+1)'(acc_q) + (SUM_W+1)'(s2_prod_q);
  assign ovf_i  = sum_i[SUM_W] ^ sum_i[SUM_W-1];
  assign ovf_q  = sum_q[SUM_W] ^ sum_q[SUM_W-1];
  assign clip_i = ovf_i ? (sum_i[SUM_W] ? SUM_MIN : SUM_MAX) : sum_i[SUM_W-1:0];
  assign clip_q = ovf_q ? (sum_q[SUM_W] ? SUM_MIN : SUM_MAX) : sum_q[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last     <= pop_item.last;
      s1_centered <= pop_item.centered;
      s1_cos      <= cos_val;
      s1_sin      <= sin_val;
      s2_last     <= s1_last;
      s2_prod_i   <= PROD_W'(s1_centered * s1_cos);
      s2_prod_q   <= PROD_W'(s1_centered * s1_sin);
    end
    if (adv && s2_valid && s2_last) begin
      in_phase_sum   <= clip_i;
      quadrature_sum <= clip_q;
      saturated      <= sat_flag || ovf_i || ovf_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      acc_i     <= '0;
      acc_q     <= '0;
      sat_flag  <= 1'b0;
    end else if (adv) begin
      s1_valid  <= !q_status.empty;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && s2_last;
      if (s2_valid) begin
        if (s2_last) begin
          acc_i    <= '0;
          acc_q    <= '0;
          sat_flag <= 1'b0;
        end else begin
          acc_i    <= clip_i;
          acc_q    <= clip_q;
          sat_flag <= sat_flag || ovf_i || ovf_q;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/iq_correlation_demodulator.sv
// Top level of the single-bin DFT (I/Q correlation) demodulator.
// Instantiates iqcd_front, iqcd_queue and iqcd_back; uses iqcd_pkg and the assert header.
`timescale 1ns / 1ps
`default_nettype none

// Takes one 12-bit offset-binary ADC sample per item, centers it, multiplies it by
// cosine and sine of a 32-bit phase and adds both products into 40-bit saturating
// sums. The phase is zero on a frame's first sample and advances by phase_step
// (written through cfg_wr_en/cfg_wr_data while the block is idle) after each one.
// An item flagged last_sample closes the frame: one result with both sums and the
// saturation flag comes out, and phase, sums and flag restart from zero. Throughput
// is one item per clock; the front side takes an item every cycle while the
// four-entry queue has room, and the back side drains one entry per cycle unless a
// result waits on out_ready. After the last item of a frame is accepted it passes
// through the queue entry, the table-lookup register and the multiply register, and
// the accumulate lands in the result register while out_valid is set by the back
// pipeline; a waiting result stalls that path.
// Cosine and sine come from a 2^(TABLE_ADDR_BITS-2) entry quarter-wave table built
// at elaboration; there is no clearing pass after reset.
module iq_correlation_demodulator #(
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        sample,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [39:0] in_phase_sum,
  output logic signed [39:0] quadrature_sum,
  output logic               saturated
);
  import iqcd_pkg::*;

  `include "iq_correlation_demodulator_assert.svh"

  // Queue handshake between the two sides.
  logic          push;
  logic          pop;
  item_t         push_item;
  item_t         pop_item;
  queue_status_t q_status;

  // Front: hold the step register, advance the phase, center each sample.
  iqcd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .last_sample (last_sample),
    .q_status    (q_status),
    .push        (push),
    .push_item   (push_item)
  );

  // Queue: absorb output stalls so the front keeps taking items while it has room.
  iqcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // Back: look up cos/sin, multiply, accumulate, register the frame result.
  iqcd_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .pop            (pop),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .in_phase_sum   (in_phase_sum),
    .quadrature_sum (quadrature_sum),
    .saturated      (saturated)
  );

  // Queue fill must track pushes and pops exactly.
  `IQCD_ASSERT_NEXT(a_queue_count, 1'b1,
                    q_status.count == $past(q_status.count) + QUEUE_CNT_W'($past(push))
                                      - QUEUE_CNT_W'($past(pop)),
                    "queue count lost track of push/pop")
  // Never more entries than the queue holds.
  `IQCD_ASSERT_NOW(a_queue_bound, 1'b1,
                   q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH),
                   "queue count above depth")
  // Leave reset with nothing queued and no result shown.
  `IQCD_ASSERT_NOW(a_reset_clean, $past(rst),
                   !out_valid && q_status.empty,
                   "state not clear after reset")

endmodule

`default_nettype wire
